// ===== rtl/assert_macros.svh =====
// Assertion shorthands used by the checker file.
// Each macro expands to one clocked concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/cscsb_pkg.sv =====
// Shared constants and types for the compressed sparse column store.
// No dependencies; used by the controller, datapath, top level and checker.
`default_nettype none

package cscsb_pkg;

  localparam int MAX_ROWS = 256;
  localparam int ROW_W    = 8;
  localparam int CFG_W    = 9;
  localparam int WORD_W   = 32;
  localparam int COUNT_W  = 13;

  // Opcodes carried on s_tuser
  localparam logic [1:0] OP_BEGIN = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result status codes carried on m_tuser
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_RANGE      = 2'd2;
  localparam logic [1:0] ST_INCOMPLETE = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic       begin_op;
    logic       load_op;
    logic       query_start;
    logic       lo_cap;
    logic       hi_cap;
    logic       walk;
    logic       resp_load;
    logic       resp_hit;
    logic [1:0] resp_status;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic complete;
    logic elem_nonzero;
    logic store_full;
    logic query_in_range;
    logic walk_hit;
    logic walk_end;
  } dp_stat_t;

  // One stored nonzero: row index and value bits
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] word;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/csc_sparse_store_build_and_lookup_unit.sv =====
// Compressed sparse column store: builds a CSC matrix from a dense column-major
// stream, then answers element lookups from it.
//
// Input stream (s_*): one beat per item. s_tuser is the opcode: begin, load, query.
// Begin clears the build counters. Load takes the next dense element in column-major
// order and stores it if nonzero (+0.0 and -0.0 are zero). Query returns the stored
// bits of (row_index, column_index) once the matrix is complete, else a status code.
// Output stream (m_*): exactly one result beat per input beat, in order.
// Begin, load and every rejected item give their result the cycle after acceptance;
// with m_tready high the next is taken in that cycle, so loads run at one per cycle.
// A valid query reads the two column pointers one after the other (single pointer memory
// port), then scans that column's stored rows one per cycle through the entry memory
// read port until the row matches or the column ends.
// s_tready is low while a query runs or while a result waits with m_tready low; a
// stalled result holds its value. Reset (rst, synchronous) empties the output, clears
// the build counters and sets both size registers to 256; stored data is not cleared.
// APB registers: row_count at 0x0, column_count at 0x4; write only while idle.
`default_nettype none

module csc_sparse_store_build_and_lookup_unit #(
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_NONZEROS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // element_word[31:0], row_index[39:32], column_index[47:40]
  input  wire logic [1:0]  s_tuser,   // opcode[1:0]
  // Output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // read_word[31:0], nonzero_count[44:32], zero[47:45]
  output logic [1:0]       m_tuser,   // status[1:0]
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [cscsb_pkg::CFG_W-1:0]   row_count;
  logic [cscsb_pkg::CFG_W-1:0]   column_count;
  cscsb_pkg::dp_cmd_t            cmd;
  cscsb_pkg::dp_stat_t           stat;
  logic [1:0]                    out_status;
  logic [cscsb_pkg::WORD_W-1:0]  out_word;
  logic [cscsb_pkg::COUNT_W-1:0] out_count;

  // Configuration registers
  assign pready = 1'b1;
  assign prdata = {{(32 - cscsb_pkg::CFG_W){1'b0}}, paddr[2] ? column_count : row_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= cscsb_pkg::CFG_W'(256);
      column_count <= cscsb_pkg::CFG_W'(256);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2]) begin
        column_count <= pwdata[cscsb_pkg::CFG_W-1:0];
      end else begin
        row_count <= pwdata[cscsb_pkg::CFG_W-1:0];
      end
    end
  end

  cscsb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cscsb_datapath #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_NONZEROS (MAX_NONZEROS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .row_count    (row_count),
    .column_count (column_count),
    .element_word (s_tdata[31:0]),
    .row_index    (s_tdata[39:32]),
    .column_index (s_tdata[47:40]),
    .out_status   (out_status),
    .out_word     (out_word),
    .out_count    (out_count)
  );

  // Output beat
  assign m_tdata = {3'b000, out_count, out_word};
  assign m_tuser = out_status;

endmodule

`default_nettype wire

// ===== rtl/cscsb_datapath.sv =====
// Datapath: build counters, entry and column pointer memories, query walk, result register.
// Depends on cscsb_pkg; driven by cscsb_ctrl through dp_cmd_t.
`default_nettype none

module cscsb_datapath #(
  parameter int MAX_COLUMNS  = 256,
  parameter int MAX_NONZEROS = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire cscsb_pkg::dp_cmd_t                cmd,
  output cscsb_pkg::dp_stat_t                    stat,
  input  wire logic [cscsb_pkg::CFG_W-1:0]       row_count,
  input  wire logic [cscsb_pkg::CFG_W-1:0]       column_count,
  input  wire logic [cscsb_pkg::WORD_W-1:0]      element_word,
  input  wire logic [cscsb_pkg::ROW_W-1:0]       row_index,
  input  wire logic [cscsb_pkg::ROW_W-1:0]       column_index,
  output logic [1:0]                             out_status,
  output logic [cscsb_pkg::WORD_W-1:0]           out_word,
  output logic [cscsb_pkg::COUNT_W-1:0]          out_count
);

  localparam int NZ_AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
  localparam int CNT_W = $clog2(MAX_NONZEROS + 1);
  localparam int COL_W = $clog2(MAX_COLUMNS + 1);

  // Build state
  logic [cscsb_pkg::ROW_W-1:0] load_row;
  logic [COL_W-1:0]            load_column;
  logic [CNT_W-1:0]            stored_total;
  logic                        complete;

  // Memories
  cscsb_pkg::entry_t entry_mem [MAX_NONZEROS];
  logic [CNT_W-1:0]  cps_mem [MAX_COLUMNS + 1];
  cscsb_pkg::entry_t entry_q;
  logic [CNT_W-1:0]  cps_q;

  // Query walk registers
  logic [cscsb_pkg::ROW_W-1:0] qrow;
  logic [COL_W-1:0]            qcol;
  logic [CNT_W-1:0]            k;
  logic [CNT_W-1:0]            hi;
  logic                        pend;

  logic [cscsb_pkg::CFG_W-1:0] rows;
  logic [COL_W-1:0]            cols;
  logic                        row_end;
  logic                        col_adv;
  logic                        do_store;
  logic                        issue;
  logic [COL_W-1:0]            load_column_next;
  logic [CNT_W-1:0]            stored_total_next;
  logic                        cps_we;
  logic [COL_W-1:0]            cps_wa;
  logic [CNT_W-1:0]            cps_wd;
  logic [COL_W-1:0]            cps_ra;

  // Clamp the configured sizes into their legal ranges
  always_comb begin
    if (row_count == '0) begin
      rows = cscsb_pkg::CFG_W'(1);
    end else if (row_count > cscsb_pkg::CFG_W'(cscsb_pkg::MAX_ROWS)) begin
      rows = cscsb_pkg::CFG_W'(cscsb_pkg::MAX_ROWS);
    end else begin
      rows = row_count;
    end
    if (column_count == '0) begin
      cols = COL_W'(1);
    end else if (32'(column_count) > 32'(MAX_COLUMNS)) begin
      cols = COL_W'(MAX_COLUMNS);
    end else begin
      cols = COL_W'(column_count);
    end
  end

  // Load bookkeeping
  always_comb begin
    row_end           = ({1'b0, load_row} + cscsb_pkg::CFG_W'(1)) >= rows;
    col_adv           = row_end && (32'(load_column) < 32'(MAX_COLUMNS));
    load_column_next  = col_adv ? load_column + COL_W'(1) : load_column;
    do_store          = cmd.load_op && stat.elem_nonzero && !stat.store_full;
    stored_total_next = do_store ? stored_total + CNT_W'(1) : stored_total;
  end

  // Column pointer port: begin writes entry 0, a column end writes the next one
  always_comb begin
    cps_we = cmd.begin_op || (cmd.load_op && col_adv);
    cps_wa = cmd.begin_op ? '0 : load_column + COL_W'(1);
    cps_wd = cmd.begin_op ? '0 : stored_total_next;
    cps_ra = cmd.query_start ? COL_W'(column_index) : qcol + COL_W'(1);
  end

  // Status toward the controller
  assign issue = k < hi;
  always_comb begin
    stat.complete       = complete;
    stat.elem_nonzero   = element_word[cscsb_pkg::WORD_W-2:0] != '0;
    stat.store_full     = stored_total >= CNT_W'(MAX_NONZEROS);
    stat.query_in_range = (32'(column_index) < 32'(load_column)) &&
                          ({1'b0, row_index} < rows);
    stat.walk_hit       = pend && (entry_q.row == qrow);
    stat.walk_end       = !issue;
  end

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (do_store) begin
      entry_mem[stored_total[NZ_AW-1:0]] <= {load_row, element_word};
    end
    entry_q <= entry_mem[k[NZ_AW-1:0]];
  end

  // Column pointer memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cps_we) begin
      cps_mem[cps_wa] <= cps_wd;
    end
    cps_q <= cps_mem[cps_ra];
  end

  // Build counters
  always_ff @(posedge clk) begin
    if (rst) begin
      load_row     <= '0;
      load_column  <= '0;
      stored_total <= '0;
      complete     <= 1'b0;
    end else if (cmd.begin_op) begin
      load_row     <= '0;
      load_column  <= '0;
      stored_total <= '0;
      complete     <= 1'b0;
    end else if (cmd.load_op) begin
      stored_total <= stored_total_next;
      load_column  <= load_column_next;
      if (row_end) begin
        load_row <= '0;
        complete <= 32'(load_column_next) >= 32'(cols);
      end else begin
        load_row <= load_row + cscsb_pkg::ROW_W'(1);
      end
    end
  end

  // Query walk: fetch lo and hi, then scan one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.hi_cap) begin
      pend <= 1'b0;
    end else if (cmd.walk) begin
      pend <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      qrow <= row_index;
      qcol <= COL_W'(column_index);
    end
    if (cmd.lo_cap) begin
      k <= cps_q;
    end else if (cmd.walk && issue) begin
      k <= k + CNT_W'(1);
    end
    if (cmd.hi_cap) begin
      hi <= cps_q;
    end
  end

  // Result register; a begin reports the cleared count
  always_ff @(posedge clk) begin
    if (cmd.resp_load) begin
      out_status <= cmd.resp_status;
      out_word   <= cmd.resp_hit ? entry_q.word : '0;
      out_count  <= cmd.begin_op ? '0 : cscsb_pkg::COUNT_W'(stored_total_next);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cscsb_ctrl.sv =====
// Controller: stream handshakes, opcode decode and query sequencing.
// Depends on cscsb_pkg; commands cscsb_datapath through dp_cmd_t.
`default_nettype none

module cscsb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [1:0]           opcode,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  input  wire cscsb_pkg::dp_stat_t  stat,
  output cscsb_pkg::dp_cmd_t        cmd
);

  typedef enum logic [1:0] {
    IDLE,
    Q_LO,
    Q_HI,
    WALK
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  // Take an item only when idle and the result register is free or draining
  assign s_tready = (state == IDLE) && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // Decode and sequencing
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (accept) begin
          case (opcode)
            cscsb_pkg::OP_BEGIN: begin
              cmd.begin_op    = 1'b1;
              cmd.resp_load   = 1'b1;
              cmd.resp_status = cscsb_pkg::ST_OK;
            end
            cscsb_pkg::OP_LOAD: begin
              cmd.resp_load = 1'b1;
              if (stat.complete) begin
                cmd.resp_status = cscsb_pkg::ST_RANGE;
              end else begin
                cmd.load_op     = 1'b1;
                cmd.resp_status = (stat.elem_nonzero && stat.store_full) ?
                                  cscsb_pkg::ST_FULL : cscsb_pkg::ST_OK;
              end
            end
            cscsb_pkg::OP_QUERY: begin
              if (!stat.complete) begin
                cmd.resp_load   = 1'b1;
                cmd.resp_status = cscsb_pkg::ST_INCOMPLETE;
              end else if (!stat.query_in_range) begin
                cmd.resp_load   = 1'b1;
                cmd.resp_status = cscsb_pkg::ST_RANGE;
              end else begin
                cmd.query_start = 1'b1;
                state_next      = Q_LO;
              end
            end
            default: begin
              cmd.resp_load   = 1'b1;
              cmd.resp_status = cscsb_pkg::ST_RANGE;
            end
          endcase
        end
      end
      Q_LO: begin
        cmd.lo_cap = 1'b1;
        state_next = Q_HI;
      end
      Q_HI: begin
        cmd.hi_cap = 1'b1;
        state_next = WALK;
      end
      WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_hit || stat.walk_end) begin
          cmd.resp_load   = 1'b1;
          cmd.resp_hit    = stat.walk_hit;
          cmd.resp_status = cscsb_pkg::ST_OK;
          state_next      = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  // State and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.resp_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cscsb_checker.sv =====
// Port-level checks for the CSC store top level, and the bind that attaches them.
// Depends on assert_macros.svh and cscsb_pkg.
`default_nettype none
`include "assert_macros.svh"

module cscsb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [1:0]  s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // A stalled result beat holds its payload
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // No new item is taken while a result waits on the receiver
  `ASSERT_NOW(a_no_take_when_stalled, clk, rst, m_tvalid && !m_tready, !s_tready)

  // Begin answers next cycle with ok and an empty count
  `ASSERT_NEXT(a_begin_resp, clk, rst,
    s_tvalid && s_tready && (s_tuser == cscsb_pkg::OP_BEGIN),
    m_tvalid && (m_tuser == cscsb_pkg::ST_OK) && (m_tdata[44:32] == 13'd0))

  // Any error status carries a zero read word
  `ASSERT_NOW(a_err_zero_word, clk, rst,
    m_tvalid && (m_tuser != cscsb_pkg::ST_OK), m_tdata[31:0] == 32'd0)

endmodule

bind csc_sparse_store_build_and_lookup_unit cscsb_checker u_checker (.*);

`default_nettype wire
